// ===== rtl/kvm_pkg.sv =====
package kvm_pkg;

    // Table size and derived widths
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = KEY_W + VAL_W;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_PRINT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_MATCH    = 3'd0,
        ST_LIST     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL,
        S_EMPTY,
        S_PRIME,
        S_SCAN,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    accept;
        logic    step;
        logic    emit;
        status_t sel;
        logic    last;
        logic    commit;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        op_t  in_op;
        logic full;
        logic empty;
        logic match;
        logic at_end;
        logic found;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/kvm_ram.sv =====
module kvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/kvm_datapath.sv =====
module kvm_datapath
    import kvm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic [1:0]              in_op,
    input  logic signed [KEY_W-1:0] in_key,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output status_t                 out_status,
    output logic signed [KEY_W-1:0] out_key,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    out_last
);

    op_t                     op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [IDX_W-1:0]        p_reg;
    logic [IDX_W-1:0]        p_next;
    logic [IDX_W-1:0]        w_reg;
    logic [IDX_W-1:0]        w_next;
    logic                    found_reg;
    logic                    found_next;
    logic [KEY_W-1:0]        pend_key_reg;
    logic [VAL_W-1:0]        pend_val_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic [VAL_W-1:0]        out_val_reg;
    logic                    out_last_reg;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic [IDX_W-1:0]        rd_addr;
    logic [ENTRY_W-1:0]      rd_data;
    logic [KEY_W-1:0]        rd_key;
    logic [VAL_W-1:0]        rd_val;
    logic                    full;
    logic                    match;
    logic                    add_write;
    logic                    rm_write;

    assign rd_key = rd_data[KEY_W-1:0];
    assign rd_val = rd_data[ENTRY_W-1:KEY_W];
    assign full   = (count_reg == COUNT_W'(DEPTH));
    assign match  = (rd_key == key_reg);

    // Table storage: add appends, remove writes survivors back in order
    assign add_write = cmd.accept && (op_t'(in_op) == OP_ADD) && !full;
    assign rm_write  = cmd.step && (op_reg == OP_REMOVE) && !match;
    assign wr_en     = add_write || rm_write;
    assign wr_addr   = add_write ? count_reg[IDX_W-1:0] : w_reg;
    assign wr_data   = add_write ? {in_value, in_key} : rd_data;
    assign rd_addr   = cmd.step ? IDX_W'(p_reg + 1'b1) : p_reg;

    kvm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Scan pointers, fill count and match flag
    always_comb
    begin
        count_next = count_reg;
        p_next     = p_reg;
        w_next     = w_reg;
        found_next = found_reg;
        if (cmd.accept)
        begin
            p_next     = '0;
            w_next     = '0;
            found_next = 1'b0;
            if (add_write)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.step)
        begin
            p_next = IDX_W'(p_reg + 1'b1);
            if (rm_write)
            begin
                w_next = IDX_W'(w_reg + 1'b1);
            end
            if (match && (op_reg != OP_PRINT))
            begin
                found_next = 1'b1;
            end
        end
        if (cmd.commit)
        begin
            count_next = COUNT_W'(w_reg);
            if (!found_reg)
            begin
                count_next = count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            p_reg     <= '0;
            w_reg     <= '0;
            found_reg <= 1'b0;
            op_reg    <= OP_ADD;
        end
        else
        begin
            count_reg <= count_next;
            p_reg     <= p_next;
            w_reg     <= w_next;
            found_reg <= found_next;
            if (cmd.accept)
            begin
                op_reg <= op_t'(in_op);
            end
        end
    end

    // Latch the search key, hold the most recent match
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= in_key;
        end
        if (cmd.step && match && (op_reg == OP_FIND))
        begin
            pend_key_reg <= rd_key;
            pend_val_reg <= rd_val;
        end
    end

    // Output register: load on emit, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.sel;
            out_last_reg   <= cmd.last;
            case (cmd.sel)
                ST_MATCH:
                begin
                    out_key_reg <= pend_key_reg;
                    out_val_reg <= pend_val_reg;
                end
                ST_LIST:
                begin
                    out_key_reg <= rd_key;
                    out_val_reg <= rd_val;
                end
                default:
                begin
                    out_key_reg <= '0;
                    out_val_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_val_reg;
    assign out_last   = out_last_reg;

    // Status towards the controller
    assign stat.op       = op_reg;
    assign stat.in_op    = op_t'(in_op);
    assign stat.full     = full;
    assign stat.empty    = (count_reg == '0);
    assign stat.match    = match;
    assign stat.at_end   = ((COUNT_W'(p_reg) + 1'b1) == count_reg);
    assign stat.found    = found_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

// ===== rtl/kvm_ctrl.sv =====
module kvm_ctrl
    import kvm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_op == OP_ADD)
                    begin
                        state_next = stat.full ? S_FULL : S_IDLE;
                    end
                    else
                    begin
                        state_next = stat.empty ? S_EMPTY : S_PRIME;
                    end
                end
            end
            S_FULL:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    state_next = (stat.op == OP_PRINT) ? S_IDLE : S_DONE;
                end
            end
            S_PRIME:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.at_end)
                begin
                    unique case (stat.op)
                        OP_PRINT:
                        begin
                            if (stat.out_free)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        OP_FIND:
                        begin
                            if (!(stat.match && stat.found) || stat.out_free)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if ((stat.op == OP_REMOVE) && stat.found)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        cmd.sel    = ST_NOTFOUND;
        cmd.accept = in_ready && in_valid;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_FULL:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = ST_FULL;
                cmd.last = 1'b1;
            end
            S_EMPTY:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = ST_EMPTY;
                cmd.last = (stat.op == OP_PRINT);
            end
            S_PRIME:
            begin
            end
            S_SCAN:
            begin
                unique case (stat.op)
                    OP_PRINT:
                    begin
                        cmd.emit = stat.out_free;
                        cmd.step = stat.out_free;
                        cmd.sel  = ST_LIST;
                        cmd.last = stat.at_end;
                    end
                    OP_FIND:
                    begin
                        // Flush the held match before taking a new one
                        cmd.sel = ST_MATCH;
                        if (stat.match && stat.found)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.step = stat.out_free;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.step = 1'b1;
                    end
                endcase
            end
            S_DONE:
            begin
                cmd.last   = 1'b1;
                cmd.commit = (stat.op == OP_REMOVE);
                if ((stat.op == OP_FIND) && stat.found)
                begin
                    cmd.emit = stat.out_free;
                    cmd.sel  = ST_MATCH;
                end
                else if (!stat.found)
                begin
                    cmd.emit = stat.out_free;
                    cmd.sel  = ST_NOTFOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/key_value_multimap_table_core.sv =====
// Insertion-ordered key/value table with duplicate keys and linear search.
// Slave channel: one request per transfer; tuser carries the command (add,
// remove, find, print), tdata carries the key and the value.
// Master channel: result items; tuser carries the status, tdata the key and
// value of a matched or listed entry (zero otherwise), tlast marks the final
// result of a request. A successful add or remove gives no result.
// Add writes the entry on acceptance; on a full table it reports full through
// the output register. Remove, find and print walk the stored entries through
// a single-port-read RAM, one entry per cycle after a read prime state while
// the output is not stalled. A full or empty status leaves from the S_FULL or
// S_EMPTY state through the output register. A find result is held back until
// the next match or the end of the walk, so that tlast can be set on the final
// one. Results leave through an output register; while the receiver stalls, a
// scan with a result to emit holds at the current entry and resumes once the
// register is taken.
// Reset clears the entry count and the control state; the table contents are
// not cleared and are never read before being written.
module key_value_multimap_table_core
    import kvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key_in, [63:32] value_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] key_out, [63:32] value_out
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);

    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    status_t                 out_status;
    logic signed [KEY_W-1:0] out_key;
    logic signed [VAL_W-1:0] out_value;

    kvm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    kvm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser),
        .in_key    (s_axis_tdata[31:0]),
        .in_value  (s_axis_tdata[63:32]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_status(out_status),
        .out_key   (out_key),
        .out_value (out_value),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields
    assign m_axis_tdata = {out_value, out_key};
    assign m_axis_tuser = out_status;

endmodule

// ===== test/key_value_multimap_table_core_tb.sv =====
`timescale 1ns / 1ps

module key_value_multimap_table_core_tb;
    import kvm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_REQUESTS = 150;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             last;
    } kv_result_t;

    // Shadow table and the results it predicts, oldest first
    class kv_table_scoreboard;
        logic [KEY_W-1:0] stored_keys[DEPTH];
        logic [VAL_W-1:0] stored_values[DEPTH];
        int               stored_count;
        kv_result_t       pending_results[$];
        int               errors;

        function new();
            stored_count = 0;
            errors       = 0;
        endfunction

        function void push_result(status_t status, logic [KEY_W-1:0] key,
                                  logic [VAL_W-1:0] value);
            kv_result_t r;
            r.status = status;
            r.key    = key;
            r.value  = value;
            r.last   = 1'b0;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Apply one accepted request to the shadow table and queue its results
        function void note_request(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
            int         first;
            int         w;
            bit         found;
            kv_result_t r;
            first = pending_results.size();
            found = 1'b0;
            case (op)
                OP_ADD:
                    if (stored_count >= DEPTH)
                        push_result(ST_FULL, '0, '0);
                    else
                    begin
                        stored_keys[stored_count]   = key;
                        stored_values[stored_count] = value;
                        stored_count++;
                    end
                OP_PRINT:
                    if (stored_count == 0)
                        push_result(ST_EMPTY, '0, '0);
                    else
                        for (int i = 0; i < stored_count; i++)
                            push_result(ST_LIST, stored_keys[i], stored_values[i]);
                default:
                begin
                    if (stored_count == 0)
                        push_result(ST_EMPTY, '0, '0);
                    if (op == OP_REMOVE)
                    begin
                        // drop every match, close up the rest in order
                        w = 0;
                        for (int i = 0; i < stored_count; i++)
                        begin
                            if (stored_keys[i] == key)
                                found = 1'b1;
                            else
                            begin
                                stored_keys[w]   = stored_keys[i];
                                stored_values[w] = stored_values[i];
                                w++;
                            end
                        end
                        stored_count = w;
                    end
                    else
                    begin
                        for (int i = 0; i < stored_count; i++)
                            if (stored_keys[i] == key)
                            begin
                                push_result(ST_MATCH, stored_keys[i], stored_values[i]);
                                found = 1'b1;
                            end
                    end
                    if (!found)
                        push_result(ST_NOTFOUND, '0, '0);
                end
            endcase
            // mark the final result of this request
            if (pending_results.size() > first)
            begin
                r      = pending_results[pending_results.size() - 1];
                r.last = 1'b1;
                pending_results[pending_results.size() - 1] = r;
            end
        endfunction

        function void report_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (exp_val !== act_val)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                         act_val);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [2:0] status, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value, logic last);
            kv_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d key %h",
                         $time, status, key);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                report_field("status", 64'(exp_r.status), 64'(status));
                report_field("key_out", 64'(exp_r.key), 64'(key));
                report_field("value_out", 64'(exp_r.value), 64'(value));
                report_field("last", 64'(exp_r.last), 64'(last));
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    kv_table_scoreboard sb;
    bit                 steady;
    bit                 hold_off_go;
    int                 idle_cycles;

    key_value_multimap_table_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request, with random gaps, and hold it until taken
    task automatic send_request(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {value, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(op, key, value);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
    endtask

    // Pick a key: mostly small or already stored, sometimes fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int c;
        c = $urandom_range(0, 9);
        if (c < 2)
            return $urandom;
        if (c < 5 && sb.stored_count > 0)
            return sb.stored_keys[$urandom_range(0, sb.stored_count - 1)];
        return $urandom_range(0, 15);
    endfunction

    // Sender: directed requests, then random ones
    initial
    begin
        int  sel;
        op_t op;
        sb            = new();
        steady        = 1'b0;
        hold_off_go   = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table on every command that reads it
        send_request(OP_PRINT, 32'h0000_0007, 32'h0);
        send_request(OP_FIND, 32'h0000_0007, 32'h0);
        send_request(OP_REMOVE, 32'h0000_0007, 32'h0);
        // extremes, then adjacent duplicate keys
        send_request(OP_ADD, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_ADD, 32'h0000_0005, 32'h0000_0000);
        send_request(OP_ADD, 32'h0000_0005, 32'hffff_ffff);
        send_request(OP_ADD, 32'h0000_0005, 32'h0000_0001);
        send_request(OP_FIND, 32'h0000_0005, 32'h0);
        send_request(OP_FIND, 32'h0000_0009, 32'h0);
        send_request(OP_PRINT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_REMOVE, 32'h0000_0005, 32'h0);
        send_request(OP_REMOVE, 32'h0000_0009, 32'h0);
        // fill up, overflow, list the full table
        for (int i = 0; i < DEPTH - 2; i++)
            send_request(OP_ADD, 32'(i), $urandom);
        send_request(OP_ADD, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_PRINT, 32'h0, 32'h0);
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 30)
                hold_off_go = 1'b1;
            steady = (n >= 90 && n < 130);
            sel = $urandom_range(0, 99);
            if (sel < 50)
                op = OP_ADD;
            else if (sel < 68)
                op = OP_REMOVE;
            else if (sel < 90)
                op = OP_FIND;
            else
                op = OP_PRINT;
            send_request(op, pick_key(), $urandom);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, steady stretch
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
                m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 28);
        end
    end

    // Check every accepted result
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                            m_axis_tlast);

    // Abort when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
